// File: hw/rtl/afmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_pkg
// Shared types, constants and helpers of the voltage text formatter.
// ----------------------------------------------------------------------------
package afmt_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int CHAR_W      = 7;
    localparam int FRAC_W      = 2;
    localparam int PROD_W      = 21;   // sample * 5000 stays below 2**21
    localparam int MV_W        = 13;   // millivolts, 0..5000
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PROD_W-1:0]  MV_SCALE  = PROD_W'(5000);
    // ceil(2**32 / 255): exact quotient for every dividend below 2**21.
    localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(16843010);

    localparam logic [FRAC_W-1:0] FRAC_RESET = 2'd2;

    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
    localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
    localparam logic [CHAR_W-1:0] CH_EQ    = 7'h3D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_U     = 7'h55;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_V     = 7'h56;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

    // Character positions of the report line template.
    typedef enum logic [4:0] {
        SL_A, SL_D, SL_C, SL_EQ1,
        SL_S2, SL_S1, SL_S0,
        SL_COMMA, SL_SP, SL_U, SL_EQ2,
        SL_VOLT, SL_POINT, SL_F2, SL_F1, SL_F0,
        SL_V, SL_CR, SL_LF
    } slot_t;

    // One classified report line as it waits in the queue.
    typedef struct packed {
        logic [3:0] s_hund;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
        logic [1:0] s_len;     // printed sample digits, 1..3
        logic [3:0] volt;
        logic [3:0] f_hund;
        logic [3:0] f_tens;
        logic [3:0] f_ones;
    } line_t;

    // One shift-and-add-3 step of binary to BCD conversion, four digits.
    function automatic logic [15:0] bcd_shift(input logic [15:0] bcd, input logic bit_in);
        logic [15:0] adj;
        adj = bcd;
        for (int i = 0; i < 4; i++) begin
            if (adj[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[14:0], bit_in};
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return CH_ZERO + {3'b000, d};
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/adc_sample_voltage_text_formatter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_sample_voltage_text_formatter_core
// Formats one converter sample per transaction into an ASCII report line.
// ----------------------------------------------------------------------------
// The first character of a line passes the 4 front stages, the queue, the line
// load and the output register after its sample transaction.
// One character leaves per cycle while the receiver is ready; a line is 13 to 19
// characters, so the sample rate is set by the character sequencer of the back part.
// Reset (rst_n low, asynchronous) empties the pipeline and the queue and sets
// the fraction digit count to 2.
// ----------------------------------------------------------------------------
module adc_sample_voltage_text_formatter_core
    import afmt_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration: fraction_digits, written while cfg_we is high.
    input  wire logic              cfg_we,
    input  wire logic [FRAC_W-1:0] cfg_wdata,
    // Sample input.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] sample
    // Character output.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [6:0] text_char, [7] zero
    output logic                   m_tlast    // line_end
);

    // The number of fraction digits, read by the back part while it walks a line.
    // The user must change it only while the block is idle; the block does not enforce it.
    logic [FRAC_W-1:0] frac_digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_digits_reg <= FRAC_RESET;
        end
        else if (cfg_we)
        begin
            frac_digits_reg <= cfg_wdata;
        end
    end

    logic              fr_valid, fr_ready;
    line_t             fr_data;
    logic              bk_valid, bk_ready;
    line_t             bk_data;
    logic [CHAR_W-1:0] out_char;

    // The front part converts the sample and its millivalue to decimal
    // digits in a short pipeline that stalls only when the queue is full.
    afmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .line_valid (fr_valid),
        .line_ready (fr_ready),
        .line_data  (fr_data)
    );

    // The queue lets the front take new samples while the back part is
    // still printing an earlier line.
    afmt_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_data),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_data  (bk_data)
    );

    // The back part emits one character per cycle into its output register while
    // the receiver is ready, and picks up the next line right after the previous line feed.
    afmt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frac_digits (frac_digits_reg),
        .line_valid  (bk_valid),
        .line_ready  (bk_ready),
        .line_data   (bk_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (out_char),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

// File: hw/rtl/afmt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_front
// Accepts samples and turns each into the decimal digits of its report line.
// ----------------------------------------------------------------------------
module afmt_front
    import afmt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] in_sample,
    output logic                     line_valid,
    input  wire logic                line_ready,
    output line_t                    line_data
);

    // Four stages: product and sample digits, millivolts, upper and lower
    // halves of the millivolt BCD conversion.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv;

    logic [PROD_W-1:0] prod_reg;
    logic [15:0]       sbcd_reg;
    logic [15:0]       sbcd_next;
    logic [1:0]        slen_reg;
    logic [1:0]        slen_next;

    logic [15:0]       sbcd2_reg, sbcd3_reg;
    logic [1:0]        slen2_reg, slen3_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [PROD_W+RECIP_W-1:0] quot_full;

    logic [5:0]        mvlo_reg;
    logic [15:0]       vbcd_reg;
    logic [15:0]       vbcd_next;
    logic [15:0]       fin_next;

    line_t             line_reg;
    line_t             line_next;

    assign adv      = !v4_reg || line_ready;
    assign in_ready = adv;

    always_comb
    begin
        sbcd_next = '0;
        for (int i = SAMPLE_W - 1; i >= 0; i--) begin
            sbcd_next = bcd_shift(sbcd_next, in_sample[i]);
        end
        if (sbcd_next[11:8] != 4'd0)
        begin
            slen_next = 2'd3;
        end
        else if (sbcd_next[7:4] != 4'd0)
        begin
            slen_next = 2'd2;
        end
        else
        begin
            slen_next = 2'd1;
        end
    end

    assign quot_full = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_255);

    always_comb
    begin
        vbcd_next = '0;
        for (int i = MV_W - 1; i >= 6; i--) begin
            vbcd_next = bcd_shift(vbcd_next, mv_reg[i]);
        end
    end

    always_comb
    begin
        fin_next = vbcd_reg;
        for (int i = 5; i >= 0; i--) begin
            fin_next = bcd_shift(fin_next, mvlo_reg[i]);
        end
        line_next.s_hund = sbcd3_reg[11:8];
        line_next.s_tens = sbcd3_reg[7:4];
        line_next.s_ones = sbcd3_reg[3:0];
        line_next.s_len  = slen3_reg;
        line_next.volt   = fin_next[15:12];
        line_next.f_hund = fin_next[11:8];
        line_next.f_tens = fin_next[7:4];
        line_next.f_ones = fin_next[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= PROD_W'(in_sample) * MV_SCALE;
            sbcd_reg  <= sbcd_next;
            slen_reg  <= slen_next;
            mv_reg    <= quot_full[RECIP_SHIFT +: MV_W];
            sbcd2_reg <= sbcd_reg;
            slen2_reg <= slen_reg;
            vbcd_reg  <= vbcd_next;
            mvlo_reg  <= mv_reg[5:0];
            sbcd3_reg <= sbcd2_reg;
            slen3_reg <= slen2_reg;
            line_reg  <= line_next;
        end
    end

    assign line_valid = v4_reg;
    assign line_data  = line_reg;

endmodule
`default_nettype wire

// File: hw/rtl/afmt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_fifo
// Short queue of classified lines between the front and back parts.
// ----------------------------------------------------------------------------
module afmt_fifo
    import afmt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire line_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output line_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    line_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/afmt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afmt_back
// Walks the report line template and emits one character per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module afmt_back
    import afmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [FRAC_W-1:0] frac_digits,
    input  wire logic              line_valid,
    output logic                   line_ready,
    input  wire line_t             line_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   out_last
);

    logic              busy_reg, busy_next;
    slot_t             slot_reg, slot_next, slot_after;
    line_t             line_reg;
    logic              oval_reg, oval_next;
    logic [CHAR_W-1:0] char_reg, char_cur;
    logic              last_reg;
    logic              out_en, at_end, pop, emit;

    assign out_en     = !oval_reg || out_ready;
    assign at_end     = busy_reg && (slot_reg == SL_LF);
    assign pop        = out_en && (!busy_reg || at_end) && line_valid;
    assign emit       = out_en && busy_reg;
    assign line_ready = out_en && (!busy_reg || at_end);

    // The character at the current position and the position that follows,
    // skipping leading sample zeros and unused fraction digits.
    always_comb
    begin
        unique case (slot_reg)
            SL_A:     begin char_cur = CH_A;                        slot_after = SL_D;     end
            SL_D:     begin char_cur = CH_D;                        slot_after = SL_C;     end
            SL_C:     begin char_cur = CH_C;                        slot_after = SL_EQ1;   end
            SL_EQ1:
            begin
                char_cur = CH_EQ;
                if (line_reg.s_len == 2'd3)
                begin
                    slot_after = SL_S2;
                end
                else if (line_reg.s_len == 2'd2)
                begin
                    slot_after = SL_S1;
                end
                else
                begin
                    slot_after = SL_S0;
                end
            end
            SL_S2:    begin char_cur = digit_char(line_reg.s_hund); slot_after = SL_S1;    end
            SL_S1:    begin char_cur = digit_char(line_reg.s_tens); slot_after = SL_S0;    end
            SL_S0:    begin char_cur = digit_char(line_reg.s_ones); slot_after = SL_COMMA; end
            SL_COMMA: begin char_cur = CH_COMMA;                    slot_after = SL_SP;    end
            SL_SP:    begin char_cur = CH_SPACE;                    slot_after = SL_U;     end
            SL_U:     begin char_cur = CH_U;                        slot_after = SL_EQ2;   end
            SL_EQ2:   begin char_cur = CH_EQ;                       slot_after = SL_VOLT;  end
            SL_VOLT:
            begin
                char_cur   = digit_char(line_reg.volt);
                slot_after = (frac_digits != 2'd0) ? SL_POINT : SL_V;
            end
            SL_POINT: begin char_cur = CH_POINT;                    slot_after = SL_F2;    end
            SL_F2:
            begin
                char_cur   = digit_char(line_reg.f_hund);
                slot_after = (frac_digits > 2'd1) ? SL_F1 : SL_V;
            end
            SL_F1:
            begin
                char_cur   = digit_char(line_reg.f_tens);
                slot_after = (frac_digits > 2'd2) ? SL_F0 : SL_V;
            end
            SL_F0:    begin char_cur = digit_char(line_reg.f_ones); slot_after = SL_V;     end
            SL_V:     begin char_cur = CH_V;                        slot_after = SL_CR;    end
            SL_CR:    begin char_cur = CH_CR;                       slot_after = SL_LF;    end
            SL_LF:    begin char_cur = CH_LF;                       slot_after = SL_A;     end
            default:  begin char_cur = CH_LF;                       slot_after = SL_A;     end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            slot_next = SL_A;
        end
        else if (emit)
        begin
            busy_next = !at_end;
            slot_next = slot_after;
        end
        oval_next = out_en ? emit : oval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= SL_A;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            line_reg <= line_data;
        end
        if (emit)
        begin
            char_reg <= char_cur;
            last_reg <= (slot_reg == SL_LF);
        end
    end

    assign out_valid = oval_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

// File: tb/tb_adc_sample_voltage_text_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_sample_voltage_text_formatter_core
// Self-checking bench for the voltage report line formatter. Every sample
// transaction is turned into the expected report characters by a local
// formatter, and each character transaction on the output is compared
// against the oldest pending one. Directed lines cover the sample and
// voltage extremes and every fraction digit setting. Random phases then
// vary the sender gaps and receiver stalls. One phase holds the receiver
// off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_adc_sample_voltage_text_formatter_core;
    import afmt_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              line_end;
    } report_char_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [FRAC_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // [7:0] sample
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // [6:0] text_char, [7] zero
    logic                   m_tlast;    // line_end

    // Characters still owed by the block, oldest first.
    report_char_t           pending_chars[$];
    logic [FRAC_W-1:0]      fraction_digits;
    int unsigned            send_idle_pct;
    int unsigned            recv_stall_pct;
    int unsigned            recv_hold_cycles;
    int unsigned            n_fail;

    adc_sample_voltage_text_formatter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Expected report line
    // ------------------------------------------------------------------
    function automatic void push_char(input logic [CHAR_W-1:0] c, input logic last);
        pending_chars.push_back('{text_char: c, line_end: last});
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_digit(input int unsigned d);
        return CH_ZERO + CHAR_W'(d);
    endfunction

    // Decimal without leading zeros, values up to 999.
    function automatic void push_decimal(input int unsigned v);
        if (v >= 100)
        begin
            push_char(ascii_digit(v / 100), 1'b0);
            push_char(ascii_digit((v / 10) % 10), 1'b0);
        end
        else if (v >= 10)
        begin
            push_char(ascii_digit(v / 10), 1'b0);
        end
        push_char(ascii_digit(v % 10), 1'b0);
    endfunction

    function automatic void format_report_line(input logic [7:0] sample,
                                               input logic [FRAC_W-1:0] digits);
        int unsigned millivolts;
        int unsigned frac;
        millivolts = (int'(sample) * 5000) / 255;
        frac       = millivolts % 1000;
        push_char(CH_A, 1'b0);
        push_char(CH_D, 1'b0);
        push_char(CH_C, 1'b0);
        push_char(CH_EQ, 1'b0);
        push_decimal(sample);
        push_char(CH_COMMA, 1'b0);
        push_char(CH_SPACE, 1'b0);
        push_char(CH_U, 1'b0);
        push_char(CH_EQ, 1'b0);
        push_decimal(millivolts / 1000);
        if (digits > 0)
        begin
            push_char(CH_POINT, 1'b0);
            push_char(ascii_digit(frac / 100), 1'b0);
            if (digits > 1)
            begin
                push_char(ascii_digit((frac / 10) % 10), 1'b0);
            end
            if (digits > 2)
            begin
                push_char(ascii_digit(frac % 10), 1'b0);
            end
        end
        push_char(CH_V, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            m_tready         = 1'b0;
            recv_hold_cycles = recv_hold_cycles - 1;
        end
        else
        begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Character checker: each output transaction against the oldest expectation.
    always @(posedge clk)
    begin
        report_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transaction: text_char=%h line_end=%b",
                       m_tdata[6:0], m_tlast);
                n_fail++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata[6:0] !== want.text_char)
                begin
                    $error("text_char: expected %h, got %h", want.text_char, m_tdata[6:0]);
                    n_fail++;
                end
                if (m_tdata[7] !== 1'b0)
                begin
                    $error("tdata pad bit: expected 0, got %b", m_tdata[7]);
                    n_fail++;
                end
                if (m_tlast !== want.line_end)
                begin
                    $error("line_end: expected %b, got %b", want.line_end, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks. All of them start and end just after a falling edge.
    // ------------------------------------------------------------------
    task automatic offer_sample(input logic [7:0] sample);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sample;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        format_report_line(sample, fraction_digits);
        @(negedge clk);
    endtask

    task automatic drain_lines();
        s_tvalid = 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(negedge clk);
        end
        // Let the last line leave the output register before anything else.
        repeat (10) @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_fraction_digits(input logic [FRAC_W-1:0] digits);
        cfg_we    = 1'b1;
        cfg_wdata = digits;
        @(negedge clk);
        cfg_we          = 1'b0;
        cfg_wdata       = 2'($urandom);
        fraction_digits = digits;
    endtask

    // Mostly short samples so one- and two-digit numbers come up often.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(9));
            1:       return 8'($urandom_range(99, 10));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset value of the fraction digit count with the sample extremes,
    // digit count boundaries and the whole-volt boundary (51 -> 1000 mV).
    task automatic test_reset_setting();
        logic [7:0] samples[10];
        samples = '{8'd0, 8'd255, 8'd1, 8'd9, 8'd10, 8'd99, 8'd100, 8'd51, 8'd128, 8'd254};
        fraction_digits = FRAC_RESET;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        foreach (samples[i])
        begin
            offer_sample(samples[i]);
        end
        drain_lines();
    endtask

    // Every fraction digit setting, the extremes first.
    task automatic test_fraction_settings();
        logic [FRAC_W-1:0] settings[4];
        settings = '{2'd0, 2'd3, 2'd1, 2'd2};
        foreach (settings[i])
        begin
            write_fraction_digits(settings[i]);
            offer_sample(8'd0);
            offer_sample(8'd255);
            offer_sample(8'd77);
            drain_lines();
        end
    endtask

    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_lines);
        write_fraction_digits(2'($urandom_range(3)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_lines)
        begin
            offer_sample(pick_sample());
        end
        drain_lines();
    endtask

    // The receiver stops for a long stretch while samples keep coming, so
    // the internal queue fills up and s_tready has to drop.
    task automatic test_output_backpressure();
        write_fraction_digits(2'd3);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 300;
        repeat (12)
        begin
            offer_sample(pick_sample());
        end
        drain_lines();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        fraction_digits  = FRAC_RESET;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        n_fail           = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_setting();
        test_fraction_settings();
        test_random_phase(0, 0, 50);
        test_random_phase(64, 0, 50);
        test_random_phase(0, 64, 50);
        test_random_phase(20, 20, 50);
        test_output_backpressure();

        if (n_fail == 0)
        begin
            $display("** adc_sample_voltage_text_formatter_core: PASSED **");
        end
        else
        begin
            $display("** adc_sample_voltage_text_formatter_core: FAILED **");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("** adc_sample_voltage_text_formatter_core: FAILED **");
        $finish;
    end

endmodule

// File: adc_sample_voltage_text_formatter_core.f
hw/rtl/afmt_pkg.sv
hw/rtl/afmt_front.sv
hw/rtl/afmt_fifo.sv
hw/rtl/afmt_back.sv
hw/rtl/adc_sample_voltage_text_formatter_core.sv
tb/tb_adc_sample_voltage_text_formatter_core.sv
